// File: rtl/core/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the table linear interpolator: table
// geometry, field widths, request kinds and the queued request beat.
// ----------------------------------------------------------------------------
package tli_pkg;

   // table geometry
   localparam int ENTRIES   = 4096;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int ROWS_BITS = IDX_BITS + 1;

   // field widths
   localparam int X_BITS = 24;
   localparam int Y_BITS = 32;

   // row count limits and reset value
   localparam logic [ROWS_BITS-1:0] ROWS_MIN   = ROWS_BITS'(2);
   localparam logic [ROWS_BITS-1:0] ROWS_MAX   = ROWS_BITS'(ENTRIES);
   localparam logic [ROWS_BITS-1:0] ROWS_RESET = ROWS_BITS'(ENTRIES);

   // arithmetic widths: |dy| * |t| and the quotient, then base plus quotient
   localparam int DY_BITS   = Y_BITS + 1;
   localparam int PROD_BITS = DY_BITS + X_BITS;
   localparam int BASE_BITS = PROD_BITS + 2;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   // saturation limits
   localparam logic [Y_BITS-1:0] Y_MAX_VAL = {1'b0, {(Y_BITS-1){1'b1}}};
   localparam logic [Y_BITS-1:0] Y_MIN_VAL = {1'b1, {(Y_BITS-1){1'b0}}};

   // request queue between front and back
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   // table memory word: {x, y}
   localparam int RAM_WIDTH = X_BITS + Y_BITS;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [IDX_BITS-1:0] idx;
      logic [X_BITS-1:0]   x;
      logic [Y_BITS-1:0]   y;
      logic [X_BITS-1:0]   q;
   } item_type;

endpackage

// File: rtl/core/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator
// A table of (x, y) sample pairs with x in descending order is loaded one
// entry per beat (req_type 0); a query beat (req_type 1) returns y linearly
// interpolated on the segment that brackets query_x (extrapolated on the
// first segment when query_x lies at or above the first x), truncated toward
// zero and saturated, or the last y with out_of_range set when the query
// lies below every x. Loads give no result. Requests enter a four-deep queue
// and results leave through a one-deep output register, so both sides stall
// independently. A query scans at most rows_in_use entries: the scan reads
// one entry per cycle through the single read port of the table memory, and
// the divider forms one quotient bit per cycle for 57 bits. The table is not
// cleared at reset; every entry a query can reach must be loaded first.
// rows_in_use must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module table_linear_interpolator import tli_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request queue side
   input  logic                      push,
   output logic                      full,
   input  logic                      req_type,
   input  logic [IDX_BITS-1:0]       req_entry_index,
   input  logic [X_BITS-1:0]         req_entry_x,
   input  logic signed [Y_BITS-1:0]  req_entry_y,
   input  logic [X_BITS-1:0]         req_query_x,
   // result queue side
   output logic                      empty,
   input  logic                      pop,
   output logic [X_BITS-1:0]         rsp_query_point,
   output logic signed [Y_BITS-1:0]  rsp_interp_value,
   output logic                      rsp_out_of_range,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [ROWS_BITS-1:0]      csr_wr_data
);

   logic [ROWS_BITS-1:0] rows_ff, rows_in;
   item_type             push_item;
   logic                 head_valid;
   item_type             head_item;
   logic                 head_pop;
   logic [Y_BITS-1:0]    interp_value;

   // rows_in_use register
   assign rows_in = csr_wr_en ? csr_wr_data : rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
      end else begin
         rows_ff <= rows_in;
      end
   end

   // pack the request beat
   always_comb begin
      push_item.kind = req_kind_type'(req_type);
      push_item.idx  = req_entry_index;
      push_item.x    = req_entry_x;
      push_item.y    = req_entry_y;
      push_item.q    = req_query_x;
   end

   tli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push),
      .push_item  (push_item),
      .full       (full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   tli_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rows_cfg         (rows_ff),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .out_empty        (empty),
      .out_pop          (pop),
      .out_query_point  (rsp_query_point),
      .out_interp_value (interp_value),
      .out_out_of_range (rsp_out_of_range)
   );

   assign rsp_interp_value = interp_value;

endmodule

// File: rtl/core/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tli_front.sv
// ----------------------------------------------------------------------------
// tli_front
// Request front end: accepts load and query beats into a short queue and
// presents the oldest one, tagged by kind, to the execution back end.
// ----------------------------------------------------------------------------
module tli_front import tli_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_en,
   input  item_type push_item,
   output logic     full,
   output logic     head_valid,
   output item_type head_item,
   input  logic     head_pop
);

   item_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]   count_ff, count_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign full       = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   assign push_ok = push_en & ~full;
   assign pop_ok  = head_pop & head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue slots
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/tli_back.sv
// ----------------------------------------------------------------------------
// tli_back
// Execution back end: writes loads into the table memory, and for a query
// scans the table for the bracketing segment, forms |dy|*|t|, divides by |dx|
// one quotient bit per cycle, rounds toward zero and saturates. The result
// waits in an output register.
// ----------------------------------------------------------------------------
module tli_back import tli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ROWS_BITS-1:0] rows_cfg,
   input  logic                 head_valid,
   input  item_type             head_item,
   output logic                 head_pop,
   output logic                 out_empty,
   input  logic                 out_pop,
   output logic [X_BITS-1:0]    out_query_point,
   output logic [Y_BITS-1:0]    out_interp_value,
   output logic                 out_out_of_range
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_SCAN = 9'b000000010,
      ST_HIT0 = 9'b000000100,
      ST_DIFF = 9'b000001000,
      ST_MUL  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_ADD  = 9'b001000000,
      ST_SAT  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [X_BITS-1:0]      q_ff, q_in;
   logic [ROWS_BITS-1:0]   issue_ff, issue_in;
   logic                   dat_vld_ff, dat_vld_in;
   logic [IDX_BITS-1:0]    dat_idx_ff, dat_idx_in;
   logic [X_BITS-1:0]      up_x_ff, up_x_in;
   logic [Y_BITS-1:0]      up_y_ff, up_y_in;
   logic [X_BITS-1:0]      lo_x_ff, lo_x_in;
   logic [Y_BITS-1:0]      lo_y_ff, lo_y_in;
   logic [X_BITS-1:0]      md_ff, md_in;
   logic [X_BITS-1:0]      mt_ff, mt_in;
   logic [DY_BITS-1:0]     mdy_ff, mdy_in;
   logic                   neg_ff, neg_in;
   logic [PROD_BITS-1:0]   num_ff, num_in;
   logic [X_BITS-1:0]      rem_ff, rem_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic [Y_BITS-1:0]      res_y_ff, res_y_in;
   logic                   res_oor_ff, res_oor_in;
   logic                   out_vld_ff, out_vld_in;
   logic [X_BITS-1:0]      out_q_ff, out_q_in;
   logic [Y_BITS-1:0]      out_y_ff, out_y_in;
   logic                   out_oor_ff, out_oor_in;

   logic [ROWS_BITS-1:0]   rows_eff;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [RAM_WIDTH-1:0]   ram_rd_data;
   logic [X_BITS-1:0]      cur_x;
   logic [Y_BITS-1:0]      cur_y;
   logic                   cur_hit;
   logic                   cur_last;
   logic [X_BITS:0]        d_diff;
   logic [X_BITS:0]        t_diff;
   logic [DY_BITS-1:0]     dy_diff;
   logic [X_BITS:0]        r_shift;
   logic                   r_ge;
   logic [X_BITS:0]        r_sub;
   logic [BASE_BITS-1:0]   ext_y;
   logic [BASE_BITS-1:0]   ext_q;
   logic [BASE_BITS-1:0]   adj;
   logic                   upper_ones;
   logic                   upper_zeros;
   logic                   out_load;

   // clamp the row count to the usable range
   always_comb begin
      if (rows_cfg < ROWS_MIN) begin
         rows_eff = ROWS_MIN;
      end else if (rows_cfg > ROWS_MAX) begin
         rows_eff = ROWS_MAX;
      end else begin
         rows_eff = rows_cfg;
      end
   end

   // table memory, word is {x, y}
   tli_ram #(
      .WIDTH (RAM_WIDTH),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_item.idx),
      .wr_data ({head_item.x, head_item.y}),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   assign cur_x    = ram_rd_data[RAM_WIDTH-1:Y_BITS];
   assign cur_y    = ram_rd_data[Y_BITS-1:0];
   assign cur_hit  = (cur_x <= q_ff);
   assign cur_last = ({1'b0, dat_idx_ff} == (rows_eff - 1'b1));

   // segment differences
   assign d_diff  = {1'b0, up_x_ff} - {1'b0, lo_x_ff};
   assign t_diff  = {1'b0, q_ff} - {1'b0, lo_x_ff};
   assign dy_diff = {up_y_ff[Y_BITS-1], up_y_ff} - {lo_y_ff[Y_BITS-1], lo_y_ff};

   // restoring divider step
   assign r_shift = {rem_ff, num_ff[PROD_BITS-1]};
   assign r_sub   = r_shift - {1'b0, md_ff};
   assign r_ge    = (r_shift >= {1'b0, md_ff});

   // base value and truncation toward zero
   assign ext_y = {{(BASE_BITS-Y_BITS){lo_y_ff[Y_BITS-1]}}, lo_y_ff};
   assign ext_q = {{(BASE_BITS-PROD_BITS){1'b0}}, num_ff};

   always_comb begin
      adj = base_ff;
      if (rem_ff != '0) begin
         if (!neg_ff && base_ff[BASE_BITS-1]) begin
            adj = base_ff + 1'b1;
         end else if (neg_ff && !base_ff[BASE_BITS-1] && (base_ff != '0)) begin
            adj = base_ff - 1'b1;
         end
      end
   end

   assign upper_ones  = &adj[BASE_BITS-1:Y_BITS-1];
   assign upper_zeros = ~|adj[BASE_BITS-1:Y_BITS-1];

   assign out_load = ~out_vld_ff | out_pop;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      q_in       = q_ff;
      issue_in   = issue_ff;
      up_x_in    = up_x_ff;
      up_y_in    = up_y_ff;
      lo_x_in    = lo_x_ff;
      lo_y_in    = lo_y_ff;
      md_in      = md_ff;
      mt_in      = mt_ff;
      mdy_in     = mdy_ff;
      neg_in     = neg_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      base_in    = base_ff;
      res_y_in   = res_y_ff;
      res_oor_in = res_oor_ff;
      out_vld_in = out_vld_ff & ~out_pop;
      out_q_in   = out_q_ff;
      out_y_in   = out_y_ff;
      out_oor_in = out_oor_ff;
      head_pop   = 1'b0;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head_item.kind == REQ_LOAD) begin
                  ram_wr_en = 1'b1;
               end else begin
                  q_in     = head_item.q;
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // one read issued per cycle, data checked in the next cycle
            if (issue_ff < rows_eff) begin
               ram_rd_en = 1'b1;
               issue_in  = issue_ff + 1'b1;
            end
            if (dat_vld_ff) begin
               if (cur_hit) begin
                  if (dat_idx_ff == '0) begin
                     up_x_in  = cur_x;
                     up_y_in  = cur_y;
                     state_in = ST_HIT0;
                  end else begin
                     lo_x_in  = cur_x;
                     lo_y_in  = cur_y;
                     state_in = ST_DIFF;
                  end
               end else if (cur_last) begin
                  res_y_in   = cur_y;
                  res_oor_in = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  up_x_in = cur_x;
                  up_y_in = cur_y;
               end
            end
         end

         ST_HIT0: begin
            // query at or above the first x: entry 1 is the lower end
            if (dat_vld_ff) begin
               lo_x_in  = cur_x;
               lo_y_in  = cur_y;
               state_in = ST_DIFF;
            end
         end

         ST_DIFF: begin
            md_in  = d_diff[X_BITS] ? X_BITS'(-d_diff) : d_diff[X_BITS-1:0];
            mt_in  = t_diff[X_BITS] ? X_BITS'(-t_diff) : t_diff[X_BITS-1:0];
            mdy_in = dy_diff[DY_BITS-1] ? -dy_diff : dy_diff;
            neg_in = d_diff[X_BITS] ^ t_diff[X_BITS] ^ dy_diff[DY_BITS-1];
            if (d_diff == '0) begin
               res_y_in   = up_y_ff;
               res_oor_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            num_in   = {{X_BITS{1'b0}}, mdy_ff} * {{DY_BITS{1'b0}}, mt_ff};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // one quotient bit per cycle, quotient shifts into num
            num_in = {num_ff[PROD_BITS-2:0], r_ge};
            rem_in = r_ge ? r_sub[X_BITS-1:0] : r_shift[X_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(PROD_BITS - 1)) begin
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            base_in  = neg_ff ? ext_y - ext_q : ext_y + ext_q;
            state_in = ST_SAT;
         end

         ST_SAT: begin
            if (!adj[BASE_BITS-1] && !upper_zeros) begin
               res_y_in = Y_MAX_VAL;
            end else if (adj[BASE_BITS-1] && !upper_ones) begin
               res_y_in = Y_MIN_VAL;
            end else begin
               res_y_in = adj[Y_BITS-1:0];
            end
            res_oor_in = 1'b0;
            state_in   = ST_OUT;
         end

         ST_OUT: begin
            if (out_load) begin
               out_vld_in = 1'b1;
               out_q_in   = q_ff;
               out_y_in   = res_y_ff;
               out_oor_in = res_oor_ff;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      dat_vld_in = ram_rd_en;
      dat_idx_in = issue_ff[IDX_BITS-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dat_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dat_vld_ff <= dat_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      issue_ff   <= issue_in;
      dat_idx_ff <= dat_idx_in;
      up_x_ff    <= up_x_in;
      up_y_ff    <= up_y_in;
      lo_x_ff    <= lo_x_in;
      lo_y_ff    <= lo_y_in;
      md_ff      <= md_in;
      mt_ff      <= mt_in;
      mdy_ff     <= mdy_in;
      neg_ff     <= neg_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      base_ff    <= base_in;
      res_y_ff   <= res_y_in;
      res_oor_ff <= res_oor_in;
      out_q_ff   <= out_q_in;
      out_y_ff   <= out_y_in;
      out_oor_ff <= out_oor_in;
   end

   assign out_empty        = ~out_vld_ff;
   assign out_query_point  = out_q_ff;
   assign out_interp_value = out_y_ff;
   assign out_out_of_range = out_oor_ff;

endmodule
